[hw/rtl/block_permutation_interleaver_macros.svh]
// Assertion macros used by the permutation interleaver sequencer.
`ifndef BLOCK_PERMUTATION_INTERLEAVER_MACROS_SVH
`define BLOCK_PERMUTATION_INTERLEAVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bpi_pkg.sv]
// Shared types and constants of the permutation interleaver.
package bpi_pkg;

    localparam int MAX_PERIOD_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int PERIOD_W   = 7;
    localparam int MAP_W      = 6;
    localparam int PAD_W      = 6;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PERIOD    = 2'd0,
        CFG_DIRECTION = 2'd1,
        CFG_PAD_COUNT = 2'd2
    } cfg_reg_t;

    localparam logic OP_LOAD          = 1'b0;
    localparam logic OP_SAMPLE        = 1'b1;
    localparam logic DIR_INTERLEAVE   = 1'b0;
    localparam logic DIR_DEINTERLEAVE = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_ctrl_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clear;
    } buf_ctrl_t;

endpackage

[hw/rtl/bpi_perm_table.sv]
// Permutation table memory: one write port, one registered read port.
module bpi_perm_table #(
    parameter int MAX_PERIOD = bpi_pkg::MAX_PERIOD_DEF,
    localparam int AddrW = $clog2(MAX_PERIOD)
) (
    input  logic                     aclk,
    input  bpi_pkg::tbl_ctrl_t       ctrl,
    input  logic [AddrW-1:0]         waddr,
    input  logic [bpi_pkg::MAP_W-1:0] wdata,
    input  logic [AddrW-1:0]         raddr,
    output logic [bpi_pkg::MAP_W-1:0] rdata
);
    import bpi_pkg::*;

    logic [MAP_W-1:0] mem [MAX_PERIOD];
    logic [MAP_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (ctrl.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/bpi_block_store.sv]
// Block buffer memory with a written bit per position; unwritten positions read as zero.
module bpi_block_store #(
    parameter int MAX_PERIOD  = bpi_pkg::MAX_PERIOD_DEF,
    parameter int SAMPLE_BITS = bpi_pkg::SAMPLE_BITS_DEF,
    localparam int AddrW = $clog2(MAX_PERIOD)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bpi_pkg::buf_ctrl_t     ctrl,
    input  logic [AddrW-1:0]       waddr,
    input  logic [SAMPLE_BITS-1:0] wdata,
    input  logic [AddrW-1:0]       raddr,
    output logic [SAMPLE_BITS-1:0] rdata
);
    import bpi_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [MAX_PERIOD];
    logic [SAMPLE_BITS-1:0] rdata_reg;
    logic                   rd_written_reg;
    logic [MAX_PERIOD-1:0]  written_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (ctrl.rd_en) begin
            rdata_reg      <= mem[raddr];
            rd_written_reg <= written_reg[raddr];
        end
    end

    // The clear of a finished block takes precedence over a write in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (ctrl.clear) begin
            written_reg <= '0;
        end else if (ctrl.wr_en) begin
            written_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rd_written_reg ? rdata_reg : '0;

endmodule

[hw/rtl/bpi_sequencer.sv]
// Control sequencer: fill counting, scatter and gather addressing, result register.
`include "block_permutation_interleaver_macros.svh"

module bpi_sequencer #(
    parameter int MAX_PERIOD  = bpi_pkg::MAX_PERIOD_DEF,
    parameter int SAMPLE_BITS = bpi_pkg::SAMPLE_BITS_DEF,
    localparam int AddrW = $clog2(MAX_PERIOD)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [bpi_pkg::PERIOD_W-1:0] period,
    input  logic                         direction,
    input  logic [bpi_pkg::PAD_W-1:0]    pad_count,
    input  logic                         cfg_clear,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic                         opcode,
    input  logic [bpi_pkg::MAP_W-1:0]    map_index,
    input  logic [bpi_pkg::MAP_W-1:0]    map_value,
    input  logic [SAMPLE_BITS-1:0]       sample,
    input  logic                         last_item,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [SAMPLE_BITS-1:0]       sample_out,
    output logic                         block_end,
    output logic                         stream_end,
    output logic                         error,
    output bpi_pkg::tbl_ctrl_t           tbl_ctrl,
    output logic [AddrW-1:0]             tbl_waddr,
    output logic [bpi_pkg::MAP_W-1:0]    tbl_wdata,
    output logic [AddrW-1:0]             tbl_raddr,
    input  logic [bpi_pkg::MAP_W-1:0]    tbl_rdata,
    output bpi_pkg::buf_ctrl_t           buf_ctrl,
    output logic [AddrW-1:0]             buf_waddr,
    output logic [SAMPLE_BITS-1:0]       buf_wdata,
    output logic [AddrW-1:0]             buf_raddr,
    input  logic [SAMPLE_BITS-1:0]       buf_rdata
);
    import bpi_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCATTER,
        ST_RD,
        ST_GBUF,
        ST_LOAD,
        ST_SINGLE
    } state_t;

    state_t                 state_reg;
    logic [PERIOD_W-1:0]    fill_reg;
    logic [PERIOD_W-1:0]    fill_next;
    logic [PERIOD_W-1:0]    p_reg;
    logic [PERIOD_W-1:0]    n_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   last_reg;
    logic                   err_reg;
    logic                   in_range_reg;
    logic                   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] m_sample_reg;
    logic                   m_block_end_reg;
    logic                   m_stream_end_reg;
    logic                   m_error_reg;

    logic                   accept;
    logic                   gather;
    logic [PERIOD_W-1:0]    fill_inc;
    logic                   fill_short;
    logic                   tbl_pos_ok;
    logic                   out_free;
    logic                   out_load;
    logic                   p_last;
    logic [PERIOD_W-1:0]    pad_ext;
    logic                   load_ok;
    logic                   done_emit;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign gather     = (direction == DIR_DEINTERLEAVE);
    assign fill_inc   = fill_reg + PERIOD_W'(1);
    assign fill_short = (fill_inc < period);
    assign tbl_pos_ok = ({1'b0, tbl_rdata} < period);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = out_free && ((state_reg == ST_LOAD) || (state_reg == ST_SINGLE));
    assign p_last     = ((p_reg + PERIOD_W'(1)) == n_reg);
    assign pad_ext    = {1'b0, pad_count};
    assign load_ok    = ({1'b0, map_index} < PERIOD_W'(MAX_PERIOD));
    assign done_emit  = out_free
                        && (((state_reg == ST_LOAD) && p_last) || (state_reg == ST_SINGLE));

    // Table port: loads write it; a scatter reads the entry for the arrival index,
    // a gather reads the entry for the output index.
    assign tbl_ctrl.wr_en = accept && (opcode == OP_LOAD) && load_ok;
    assign tbl_ctrl.rd_en = (accept && (opcode == OP_SAMPLE) && !gather)
                            || ((state_reg == ST_RD) && gather);
    assign tbl_waddr      = map_index[AddrW-1:0];
    assign tbl_wdata      = map_value;
    assign tbl_raddr      = (state_reg == ST_IDLE) ? fill_reg[AddrW-1:0] : p_reg[AddrW-1:0];

    // Buffer port: a scatter writes at the table position, a raw store at the fill index.
    assign buf_ctrl.wr_en = (accept && (opcode == OP_SAMPLE) && gather)
                            || ((state_reg == ST_SCATTER) && tbl_pos_ok);
    assign buf_ctrl.rd_en = ((state_reg == ST_RD) && !gather) || (state_reg == ST_GBUF);
    assign buf_ctrl.clear = cfg_clear || done_emit;
    assign buf_waddr      = (state_reg == ST_SCATTER) ? tbl_rdata[AddrW-1:0]
                                                      : fill_reg[AddrW-1:0];
    assign buf_wdata      = (state_reg == ST_SCATTER) ? sample_reg : sample;
    assign buf_raddr      = gather ? tbl_rdata[AddrW-1:0] : p_reg[AddrW-1:0];

    // A register write that discards the partial block wins over any fill update.
    always_comb begin
        priority if (cfg_clear) begin
            fill_next = '0;
        end else if (accept && (opcode == OP_SAMPLE) && gather) begin
            fill_next = fill_inc;
        end else if (state_reg == ST_SCATTER) begin
            fill_next = fill_inc;
        end else if (done_emit) begin
            fill_next = '0;
        end else begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (opcode == OP_SAMPLE)) begin
                        sample_reg <= sample;
                        last_reg   <= last_item;
                        p_reg      <= '0;
                        if (!gather) begin
                            state_reg <= ST_SCATTER;
                        end else begin
                            priority if (fill_short && !last_item) begin
                                state_reg <= ST_IDLE;
                            end else if (fill_short) begin
                                err_reg   <= 1'b1;
                                state_reg <= ST_SINGLE;
                            end else if (last_item && (pad_ext >= period)) begin
                                err_reg   <= 1'b0;
                                state_reg <= ST_SINGLE;
                            end else begin
                                n_reg     <= last_item ? (period - pad_ext) : period;
                                state_reg <= ST_RD;
                            end
                        end
                    end
                end
                ST_SCATTER: begin
                    p_reg <= '0;
                    n_reg <= period;
                    if (fill_short && !last_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= gather ? ST_GBUF : ST_LOAD;
                end
                ST_GBUF: begin
                    in_range_reg <= tbl_pos_ok;
                    state_reg    <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (out_free) begin
                        m_tvalid_reg     <= 1'b1;
                        m_sample_reg     <= (gather && !in_range_reg) ? '0 : buf_rdata;
                        m_block_end_reg  <= p_last;
                        m_stream_end_reg <= p_last && last_reg;
                        m_error_reg      <= 1'b0;
                        if (p_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            p_reg     <= p_reg + PERIOD_W'(1);
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_SINGLE: begin
                    if (out_free) begin
                        m_tvalid_reg     <= 1'b1;
                        m_sample_reg     <= '0;
                        m_block_end_reg  <= 1'b1;
                        m_stream_end_reg <= 1'b1;
                        m_error_reg      <= err_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign sample_out = m_sample_reg;
    assign block_end  = m_block_end_reg;
    assign stream_end = m_stream_end_reg;
    assign error      = m_error_reg;

    `BPI_ASSERT_SAME(a_fill_below_period, state_reg == ST_IDLE, fill_reg < period, "fill count reached the block length while idle")
    `BPI_ASSERT_SAME(a_emit_index_in_run, state_reg == ST_LOAD, p_reg < n_reg, "emission index ran past the run length")
    `BPI_ASSERT_SAME(a_buf_single_access, buf_ctrl.wr_en, !buf_ctrl.rd_en, "block buffer written and read in one cycle")
    `BPI_ASSERT_NEXT(a_load_shows_result, (state_reg == ST_LOAD) && out_free, m_tvalid_reg, "result load did not reach the output register")

endmodule

[hw/rtl/block_permutation_interleaver.sv]
// Top level of the permutation block interleaver and deinterleaver.
//
// Input channel s_*: each transfer is either a table load (s_tuser low) that writes one
// permutation entry, or a data sample (s_tuser high) with s_tlast on the final sample.
// Result channel m_*: permuted samples; m_tlast closes the run caused by one input, and
// m_tuser carries the end-of-stream and error flags.
// Configuration: cfg_wr_en, cfg_addr and cfg_wdata write period, direction and pad count;
// a write of period or direction discards a partial block.
// Sequence: a load writes the table directly, an interleave sample reads the table and
// then writes the buffer, and a deinterleave sample writes the buffer directly. Each
// result of a block needs a buffer read and then the output load when interleaving, and
// a dependent read of the table, then of the buffer, then the output load when deinterleaving,
// since each memory has one registered read port. Input is not taken while a block is being emitted.
// Reset clears the configuration to its defaults, the fill count and the written bits;
// the table memory is not cleared and must be loaded before use.
// When the receiver stalls, the result register holds its transfer and emission waits;
// the block takes new input again once the last result of a run sits in that register.
module block_permutation_interleaver #(
    parameter int MAX_PERIOD  = bpi_pkg::MAX_PERIOD_DEF,
    parameter int SAMPLE_BITS = bpi_pkg::SAMPLE_BITS_DEF,
    localparam int InDataW  = ((2 * bpi_pkg::MAP_W + SAMPLE_BITS + 7) / 8) * 8,
    localparam int OutDataW = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bpi_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bpi_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: map_index, map_value, sample, zero fill
    input  logic [InDataW-1:0]             s_tdata,
    input  logic                           s_tlast,
    // s_tuser: opcode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: sample_out, zero fill
    output logic [OutDataW-1:0]            m_tdata,
    output logic                           m_tlast,
    // m_tuser: stream_end, error
    output logic [1:0]                     m_tuser
);
    import bpi_pkg::*;

    localparam int AddrW = $clog2(MAX_PERIOD);

    logic [PERIOD_W-1:0]    period_reg;
    logic                   direction_reg;
    logic [PAD_W-1:0]       pad_count_reg;
    logic [PERIOD_W-1:0]    period_next;
    logic                   cfg_clear;

    logic [MAP_W-1:0]       map_index;
    logic [MAP_W-1:0]       map_value;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   stream_end;
    logic                   error;

    tbl_ctrl_t              tbl_ctrl;
    logic [AddrW-1:0]       tbl_waddr;
    logic [MAP_W-1:0]       tbl_wdata;
    logic [AddrW-1:0]       tbl_raddr;
    logic [MAP_W-1:0]       tbl_rdata;
    buf_ctrl_t              buf_ctrl;
    logic [AddrW-1:0]       buf_waddr;
    logic [SAMPLE_BITS-1:0] buf_wdata;
    logic [AddrW-1:0]       buf_raddr;
    logic [SAMPLE_BITS-1:0] buf_rdata;

    // A period of zero is taken as one, and anything above the table depth is clamped.
    always_comb begin
        if (cfg_wdata == '0) begin
            period_next = PERIOD_W'(1);
        end else if (cfg_wdata > PERIOD_W'(MAX_PERIOD)) begin
            period_next = PERIOD_W'(MAX_PERIOD);
        end else begin
            period_next = cfg_wdata;
        end
    end

    assign cfg_clear = cfg_wr_en && ((cfg_addr == CFG_PERIOD) || (cfg_addr == CFG_DIRECTION));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= PERIOD_W'(MAX_PERIOD);
            direction_reg <= DIR_INTERLEAVE;
            pad_count_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_PERIOD:    period_reg    <= period_next;
                CFG_DIRECTION: direction_reg <= cfg_wdata[0];
                CFG_PAD_COUNT: pad_count_reg <= cfg_wdata[PAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign map_index = s_tdata[MAP_W-1:0];
    assign map_value = s_tdata[2*MAP_W-1:MAP_W];
    assign sample    = s_tdata[2*MAP_W+SAMPLE_BITS-1:2*MAP_W];

    bpi_sequencer #(
        .MAX_PERIOD  (MAX_PERIOD),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sequencer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .period     (period_reg),
        .direction  (direction_reg),
        .pad_count  (pad_count_reg),
        .cfg_clear  (cfg_clear),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .opcode     (s_tuser),
        .map_index  (map_index),
        .map_value  (map_value),
        .sample     (sample),
        .last_item  (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .sample_out (sample_out),
        .block_end  (m_tlast),
        .stream_end (stream_end),
        .error      (error),
        .tbl_ctrl   (tbl_ctrl),
        .tbl_waddr  (tbl_waddr),
        .tbl_wdata  (tbl_wdata),
        .tbl_raddr  (tbl_raddr),
        .tbl_rdata  (tbl_rdata),
        .buf_ctrl   (buf_ctrl),
        .buf_waddr  (buf_waddr),
        .buf_wdata  (buf_wdata),
        .buf_raddr  (buf_raddr),
        .buf_rdata  (buf_rdata)
    );

    bpi_perm_table #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_perm_table (
        .aclk  (aclk),
        .ctrl  (tbl_ctrl),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    bpi_block_store #(
        .MAX_PERIOD  (MAX_PERIOD),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_block_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (buf_ctrl),
        .waddr   (buf_waddr),
        .wdata   (buf_wdata),
        .raddr   (buf_raddr),
        .rdata   (buf_rdata)
    );

    assign m_tdata = OutDataW'(sample_out);
    assign m_tuser = {error, stream_end};

endmodule

[sim/tb_top.sv]
// Self-checking testbench of the permutation block interleaver and deinterleaver.
module tb_top;
    import bpi_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          NUM_PHASES = 10;

    typedef struct packed {
        logic [15:0] sample_out;
        logic        block_end;
        logic        stream_end;
        logic        error;
    } perm_result_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    // Predicts the permuted samples from the accepted transfers and checks the results.
    class perm_scoreboard;
        int unsigned  blk_len;
        logic         dir;
        logic [5:0]   pad;
        logic [5:0]   map_tbl [64];
        logic [15:0]  blk_buf [64];
        int unsigned  fill;
        logic [63:0]  wr_mask;
        perm_result_t expected_samples [$];
        int unsigned  failures;

        function new();
            blk_len  = 64;
            dir      = DIR_INTERLEAVE;
            pad      = '0;
            fill     = 0;
            wr_mask  = '0;
            failures = 0;
        endfunction

        function void clear_block();
            fill    = 0;
            wr_mask = '0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [6:0] value);
            case (idx)
                CFG_PERIOD: begin
                    if (value == 0) blk_len = 1;
                    else if (value > 64) blk_len = 64;
                    else blk_len = value;
                    clear_block();
                end
                CFG_DIRECTION: begin
                    dir = value[0];
                    clear_block();
                end
                CFG_PAD_COUNT: begin
                    pad = value[5:0];
                end
                default: ;
            endcase
        endfunction

        function void push(logic [15:0] v, bit blk_end, bit str_end, bit err);
            perm_result_t r;
            r.sample_out = v;
            r.block_end  = blk_end;
            r.stream_end = str_end;
            r.error      = err;
            expected_samples.push_back(r);
        endfunction

        function void take_item(logic op, logic [5:0] idx, logic [5:0] val,
                                logic [15:0] smp, logic last);
            int unsigned pos;
            int unsigned n;
            if (op == OP_LOAD) begin
                map_tbl[idx] = val;
                return;
            end
            if (fill >= blk_len) clear_block();
            if (dir == DIR_INTERLEAVE) begin
                pos = map_tbl[fill];
                // A table value outside the block drops the sample.
                if (pos < blk_len) begin
                    blk_buf[pos] = smp;
                    wr_mask[pos] = 1'b1;
                end
                fill++;
                if (fill < blk_len && !last) return;
                for (int unsigned p = 0; p < blk_len; p++)
                    push(wr_mask[p] ? blk_buf[p] : 16'h0, p + 1 == blk_len,
                         (p + 1 == blk_len) && last, 1'b0);
                clear_block();
                return;
            end
            blk_buf[fill] = smp;
            fill++;
            if (fill < blk_len) begin
                if (!last) return;
                // The stream has ended off a block boundary.
                push(16'h0, 1'b1, 1'b1, 1'b1);
                clear_block();
                return;
            end
            n = blk_len;
            if (last) begin
                if (pad >= blk_len) begin
                    push(16'h0, 1'b1, 1'b1, 1'b0);
                    clear_block();
                    return;
                end
                n = blk_len - pad;
            end
            for (int unsigned p = 0; p < n; p++) begin
                pos = map_tbl[p];
                push((pos < blk_len) ? blk_buf[pos] : 16'h0, p + 1 == n,
                     (p + 1 == n) && last, 1'b0);
            end
            clear_block();
        endfunction

        function void check_sample(perm_result_t got);
            perm_result_t want;
            if (expected_samples.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: sample %h last %b end %b err %b",
                             got.sample_out, got.block_end, got.stream_end, got.error);
                return;
            end
            want = expected_samples.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                             want.sample_out, want.block_end, want.stream_end, want.error,
                             got.sample_out, got.block_end, got.stream_end, got.error);
            end
        endfunction

        function int unsigned pending();
            return expected_samples.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    perm_scoreboard sb;
    int unsigned    cycles = 0;
    int unsigned    burst_left = 0;
    bit             hold_req = 1'b0;

    always #1 aclk = ~aclk;

    block_permutation_interleaver i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Both channels are observed at the clock edge, before any update of that edge.
    always @(posedge aclk) begin
        if (aresetn && sb != null) begin
            if (s_tvalid && s_tready)
                sb.take_item(s_tuser, s_tdata[5:0], s_tdata[11:6], s_tdata[27:12], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_sample({m_tdata[15:0], m_tlast, m_tuser[0], m_tuser[1]});
        end
    end

    // Receiver: changes its stall pattern now and then, and holds off once for a long time.
    initial begin
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit          hold_done;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_RANDOM:   m_tready <= $urandom_range(0, 1);
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 7) == 0);
                    RX_PERIODIC: m_tready <= (cycles % 5 != 0);
                    default:     m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Offers one transfer and waits for it; bursts end in a random gap.
    task automatic send_item(input logic op, input logic [5:0] idx, input logic [5:0] val,
                             input logic [15:0] smp, input logic last);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, smp, val, idx};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 40);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 4)) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_load(input logic [5:0] idx, input logic [5:0] val);
        send_item(OP_LOAD, idx, val, 16'($urandom), 1'($urandom));
    endtask

    task automatic send_sample(input logic [15:0] smp, input logic last);
        send_item(OP_SAMPLE, 6'($urandom), 6'($urandom), smp, last);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [6:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Lets the block run dry so that the registers may be written. The first edge
    // makes sure the monitor has taken the last accepted transfer into account.
    task automatic settle();
        if (s_tvalid) s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned  phase_period [NUM_PHASES];
        int unsigned  eff;
        int unsigned  budget;
        int unsigned  sent;
        int unsigned  len;
        int unsigned  pick;
        int unsigned  n;
        logic [6:0]   pad_val;
        logic         closed;
        phase_period = '{0, 127, 3, 2, 5, 8, 64, 4, 16, 7};
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every table entry is written before any sample reads it.
        for (int i = 0; i < 64; i++)
            send_load(6'(i), 6'(63 - i));
        settle();

        write_reg(CFG_PERIOD, 7'd4);
        write_reg(CFG_DIRECTION, 7'(DIR_INTERLEAVE));
        write_reg(CFG_PAD_COUNT, 7'd0);
        send_load(6'd0, 6'd2);
        send_load(6'd1, 6'd0);
        send_load(6'd2, 6'd3);
        send_load(6'd3, 6'd1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h1234, 1'b0);
        send_sample(16'hA5A5, 1'b1);
        // A duplicate position overwrites, two positions stay empty, and one sample
        // falls outside the block.
        send_load(6'd1, 6'd2);
        send_load(6'd3, 6'd63);
        send_sample(16'h5A5A, 1'b0);
        send_sample(16'hC3C3, 1'b0);
        send_sample(16'h0F0F, 1'b0);
        send_sample(16'hF0F0, 1'b0);
        // The stream ends part-way through a block.
        send_sample(16'h8001, 1'b0);
        send_sample(16'h7FFE, 1'b1);
        settle();

        write_reg(CFG_DIRECTION, 7'(DIR_DEINTERLEAVE));
        write_reg(CFG_PAD_COUNT, 7'd1);
        send_sample(16'h1111, 1'b0);
        send_sample(16'h2222, 1'b0);
        send_sample(16'h3333, 1'b0);
        send_sample(16'h4444, 1'b1);
        // Off a block boundary.
        send_sample(16'h5555, 1'b0);
        send_sample(16'h6666, 1'b0);
        send_sample(16'h7777, 1'b1);
        settle();
        // Padding that covers the whole final block.
        write_reg(CFG_PAD_COUNT, 7'd63);
        send_sample(16'h9999, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'hBBBB, 1'b0);
        send_sample(16'hCCCC, 1'b1);
        settle();

        hold_req = 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (phase_period[ph] == 0) eff = 1;
            else if (phase_period[ph] > 64) eff = 64;
            else eff = phase_period[ph];
            case ($urandom_range(0, 3))
                0:       pad_val = 7'd0;
                1:       pad_val = 7'd63;
                2:       pad_val = 7'($urandom_range(0, eff));
                default: pad_val = 7'($urandom_range(0, 127));
            endcase
            write_reg(CFG_PERIOD, 7'(phase_period[ph]));
            write_reg(CFG_DIRECTION, 7'(ph % 2));
            write_reg(CFG_PAD_COUNT, pad_val);
            budget = (eff == 64) ? 60 : 30;
            sent = 0;
            while (sent < budget) begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_load(6'($urandom), 6'($urandom));
                    sent += n;
                end else begin
                    len = ((eff == 64) ? 1 : $urandom_range(1, 3)) * eff;
                    // Mostly whole blocks; now and then a stream that breaks off early
                    // or runs on without an end mark.
                    if (pick == 9 && eff > 1) len -= $urandom_range(1, eff - 1);
                    closed = (pick != 8);
                    for (int unsigned k = 0; k < len; k++)
                        send_sample(16'($urandom), closed && (k + 1 == len));
                    sent += len;
                end
            end
            settle();
        end

        if (sb.pending() != 0) sb.failures++;
        if (sb.failures == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
